// File: hdl/keyframe_priority_frame_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key-frame priority frame queue
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PRIORITY_FRAME_QUEUE_MACROS_SVH
`define KEYFRAME_PRIORITY_FRAME_QUEUE_MACROS_SVH

// same-cycle implication
`define KPFQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KPFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/kpfq_pkg.sv
// ----------------------------------------------------------------------------
// kpfq_pkg
// Shared constants and types for the key-frame priority frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kpfq_pkg;

	localparam int DEPTH       = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int FLUSH_W     = $clog2(MAX_RESULTS);

	localparam int HANDLE_W = 32;
	localparam int LENGTH_W = 22;
	localparam int NUMBER_W = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 6;
	localparam int COUNT_W  = 6;

	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_PUSH_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PUSH_REJ    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POP_OK      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FLUSH_ENTRY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FLUSH_EMPTY = 3'd5;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] length;
		logic                key;
		logic [NUMBER_W-1:0] number;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic occ;    // cell lies below the held count
		logic load;   // take the incoming frame
		logic shift;  // take the upper neighbour's entry
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/kpfq_cell.sv
// ----------------------------------------------------------------------------
// kpfq_cell
// One queue slot: holds an entry, loads a new frame or takes its upper
// neighbour's entry, and extends the newest-non-key search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module kpfq_cell
	import kpfq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire entry_t    new_entry,
	input  wire entry_t    upper_entry,
	input  wire logic      nk_above,   // occupied non-key entry somewhere above
	output entry_t         entry,
	output logic           nk_here,    // occupied non-key at or above this cell
	output logic           victim      // this cell is the newest non-key entry
);

	entry_t data_q;
	logic   nk_self;

	assign nk_self = ctl.occ & ~data_q.key;
	assign nk_here = nk_self | nk_above;
	assign victim  = nk_self & ~nk_above;
	assign entry   = data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= new_entry;
		end else if (ctl.shift) begin
			data_q <= upper_entry;
		end
	end

endmodule

`default_nettype wire

// File: hdl/keyframe_priority_frame_queue.sv
// ----------------------------------------------------------------------------
// keyframe_priority_frame_queue
// Push, pop: taken on start when idle; executed in the single S_RUN state, then
//   the result is registered and strobed. Busy holds off the next command.
// Flush of n held entries: n results (at most 32; one empty result if n is 0)
//   on consecutive cycles; busy until the last. One-cycle strobes, never stalled.
// Reset (arst_n low, async): queue empty, limit register 0 (full depth).
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_priority_frame_queue
	import kpfq_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command beat
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [HANDLE_W-1:0] frame_handle,
	input  wire logic [LENGTH_W-1:0] frame_length,
	input  wire logic                is_key_frame,
	input  wire logic [NUMBER_W-1:0] frame_number,
	// limit register write
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data,
	// result beat
	output logic                     strobe,
	output logic [STATUS_W-1:0]      status,
	output logic [HANDLE_W-1:0]      out_handle,
	output logic [LENGTH_W-1:0]      out_length,
	output logic                     out_key_frame,
	output logic [NUMBER_W-1:0]      out_number,
	output logic                     evicted_valid,
	output logic [HANDLE_W-1:0]      evicted_handle,
	output logic [COUNT_W-1:0]       entry_count,
	output logic                     last
);

`include "keyframe_priority_frame_queue_macros.svh"

	// sequencer states
	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CFG_W-1:0]   max_entries_q;
	logic [FLUSH_W-1:0] flushed_q;
	logic [KIND_W-1:0]  kind_q;
	entry_t             frame_q;

	// result output register
	logic                strobe_q;
	logic [STATUS_W-1:0] status_q;
	entry_t              out_q;
	logic                ev_valid_q;
	logic [HANDLE_W-1:0] ev_handle_q;
	logic [CNT_W-1:0]    res_count_q;
	logic                last_q;

	// cell row
	cell_ctl_t     cell_ctl  [DEPTH];
	entry_t        cell_data [DEPTH];
	logic [DEPTH:0] nk_chain;
	logic [DEPTH-1:0] victim;

	// execute-cycle decisions
	logic [CNT_W-1:0]    limit;
	logic                take;
	logic                res_strobe;
	logic [STATUS_W-1:0] res_status;
	logic                res_with_entry;
	logic                res_ev_valid;
	logic [HANDLE_W-1:0] res_ev_handle;
	logic                res_last;
	logic [CNT_W-1:0]    cnt_nxt;
	logic                done;
	logic                load_act;
	logic [CNT_W-1:0]    load_pos;
	logic                shift_all;
	logic                shift_evict;
	logic [HANDLE_W-1:0] victim_handle;

	assign busy      = (state_q == S_RUN);
	assign cfg_ready = 1'b1;
	assign take      = start & ~busy;

	// limit of zero, or beyond the built depth, means full depth
	always_comb begin
		if (max_entries_q == '0 || int'(max_entries_q) > DEPTH) begin
			limit = CNT_W'(DEPTH);
		end else begin
			limit = CNT_W'(max_entries_q);
		end
	end

	// eviction target: newest occupied non-key cell, else the head
	always_comb begin
		victim_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			victim_handle = victim_handle | ({HANDLE_W{victim[i]}} & cell_data[i].handle);
		end
		if (!nk_chain[0]) begin
			victim_handle = cell_data[0].handle;
		end
	end

	// execute cycle: decide the result and how the row moves
	always_comb begin
		res_strobe     = 1'b0;
		res_status     = ST_PUSH_REJ;
		res_with_entry = 1'b0;
		res_ev_valid   = 1'b0;
		res_ev_handle  = '0;
		res_last       = 1'b1;
		cnt_nxt        = count_q;
		done           = 1'b1;
		load_act       = 1'b0;
		load_pos       = count_q;
		shift_all      = 1'b0;
		shift_evict    = 1'b0;
		if (state_q == S_RUN) begin
			unique case (kind_q)
				KIND_PUSH: begin
					res_strobe = 1'b1;
					if (count_q < limit) begin
						res_status = ST_PUSH_OK;
						load_act   = 1'b1;
						cnt_nxt    = count_q + 1'b1;
					end else if (frame_q.key && count_q != '0) begin
						// drop the victim, close the gap, append on top
						res_status    = ST_PUSH_OK;
						res_ev_valid  = 1'b1;
						res_ev_handle = victim_handle;
						shift_evict   = 1'b1;
						load_act      = 1'b1;
						load_pos      = count_q - 1'b1;
					end else begin
						res_status = ST_PUSH_REJ;
					end
				end
				KIND_POP: begin
					res_strobe = 1'b1;
					if (count_q == '0) begin
						res_status = ST_POP_EMPTY;
					end else begin
						res_status     = ST_POP_OK;
						res_with_entry = 1'b1;
						shift_all      = 1'b1;
						cnt_nxt        = count_q - 1'b1;
					end
				end
				KIND_FLUSH: begin
					res_strobe = 1'b1;
					if (count_q == '0) begin
						res_status = ST_FLUSH_EMPTY;
					end else begin
						res_status     = ST_FLUSH_ENTRY;
						res_with_entry = 1'b1;
						shift_all      = 1'b1;
						cnt_nxt        = count_q - 1'b1;
						res_last       = (count_q == CNT_W'(1)) ||
						                 (flushed_q == FLUSH_W'(MAX_RESULTS - 1));
						done           = res_last;
					end
				end
				default: begin
					res_strobe = 1'b0;
				end
			endcase
		end
	end

	// per-cell control: load beats shift, eviction shifts cells at or above victim
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].occ   = (CNT_W'(i) < count_q);
			cell_ctl[i].load  = load_act && (load_pos == CNT_W'(i));
			cell_ctl[i].shift = shift_all | (shift_evict & ~nk_chain[i+1]);
		end
	end

	assign nk_chain[DEPTH] = 1'b0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t upper;
		if (g == DEPTH - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_data[g+1];
		end
		kpfq_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[g]),
			.new_entry   (frame_q),
			.upper_entry (upper),
			.nk_above    (nk_chain[g+1]),
			.entry       (cell_data[g]),
			.nk_here     (nk_chain[g]),
			.victim      (victim[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			max_entries_q <= '0;
			flushed_q     <= '0;
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= res_strobe;
			count_q  <= cnt_nxt;
			if (cfg_valid && cfg_ready) begin
				max_entries_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					flushed_q <= '0;
					// unknown kind is swallowed without a result
					if (take && kind != KIND_PUSH && kind != KIND_POP && kind != KIND_FLUSH) begin
						state_q <= S_IDLE;
					end else if (take) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					flushed_q <= flushed_q + 1'b1;
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// captured command and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q         <= kind;
			frame_q.handle <= frame_handle;
			frame_q.length <= frame_length;
			frame_q.key    <= is_key_frame;
			frame_q.number <= frame_number;
		end
		status_q    <= res_status;
		out_q       <= res_with_entry ? cell_data[0] : '0;
		ev_valid_q  <= res_ev_valid;
		ev_handle_q <= res_ev_handle;
		res_count_q <= cnt_nxt;
		last_q      <= res_last;
	end

	assign strobe         = strobe_q;
	assign status         = status_q;
	assign out_handle     = out_q.handle;
	assign out_length     = out_q.length;
	assign out_key_frame  = out_q.key;
	assign out_number     = out_q.number;
	assign evicted_valid  = ev_valid_q;
	assign evicted_handle = ev_handle_q;
	assign entry_count    = COUNT_W'(res_count_q);
	assign last           = last_q;

	`KPFQ_ASSERT_NOW(a_count_bound, 1'b1, int'(count_q) <= DEPTH, "held count beyond depth")
	`KPFQ_ASSERT_NOW(a_evict_is_push, strobe_q && ev_valid_q, status_q == ST_PUSH_OK, "eviction on a non-push result")
	`KPFQ_ASSERT_NEXT(a_single_exec, state_q == S_RUN && kind_q != KIND_FLUSH, state_q == S_IDLE, "push or pop ran past one cycle")
	`KPFQ_ASSERT_NOW(a_flush_pending, strobe_q && !last_q, state_q == S_RUN, "intermediate flush beat with sequencer idle")

endmodule

`default_nettype wire
